// ===== rtl/core/ste_pkg.sv =====
`default_nettype none

package ste_pkg;

  // Field widths of the two channels.
  localparam int TS_W   = 24;
  localparam int IDX_W  = 7;
  localparam int OUT_W  = 16;
  localparam int FREQ_W = 24;

  // Half of the embedding dimension; indices wrap modulo this value.
  localparam int EMBED_HALF = 128;
  localparam int IDX_COUNT  = 2 ** IDX_W;

  // Exponent and Taylor constants used to build the frequency table.
  localparam longint unsigned LOG2_1E4_Q32 = 64'd57070290109;
  localparam longint unsigned LN2_Q30      = 64'd744261118;
  localparam longint unsigned FREQ_MAX     = 64'hFF_FFFF;

  // Angle arithmetic: product is Q37, reduction modulo two pi in Q37.
  localparam int ANG_W = TS_W + FREQ_W;
  localparam int R_W   = 40;
  localparam int REM_W = R_W + 1;
  localparam int Q_W   = 9;

  localparam logic [R_W-1:0] TWO_PI_Q37     = 40'd863554413089;
  localparam logic [R_W-1:0] PI_Q37         = 40'd431777206545;
  localparam logic [R_W-1:0] HALF_PI_Q37    = 40'd215888603272;
  localparam logic [R_W-1:0] THREE_HALF_PI  = TWO_PI_Q37 - HALF_PI_Q37;

  // Quotient estimate: q = (angle[47:32] * MOD_RECIP) >> MOD_SHIFT.
  localparam int HI_W      = ANG_W - 32;
  localparam int MOD_SHIFT = 24;
  localparam int RECIP_W   = 17;
  localparam longint unsigned MOD_RECIP_FULL =
    (64'd1 << (32 + MOD_SHIFT)) / {24'd0, TWO_PI_Q37};
  localparam logic [RECIP_W-1:0] MOD_RECIP = MOD_RECIP_FULL[RECIP_W-1:0];
  localparam int QPROD_W = HI_W + RECIP_W;

  // CORDIC datapath in Q30.
  localparam int CORDIC_W         = 34;
  localparam int CORDIC_STEPS     = 24;
  localparam int CORDIC_PER_STAGE = 3;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int FOLD_SHIFT       = 7;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  typedef logic [FREQ_W-1:0] freq_rom_t [IDX_COUNT];

  // Quotient of a nonnegative value by a small divisor, by shift and subtract.
  function automatic longint unsigned udiv_small(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Frequency 10000^(-i/EMBED_HALF) as unsigned Q0.24, evaluated at elaboration.
  function automatic logic [FREQ_W-1:0] freq_q24(input int unsigned idx);
    longint unsigned e;
    longint unsigned n;
    longint unsigned f;
    longint unsigned x;
    longint unsigned w;
    longint          term;
    longint          sum;
    longint          p;
    int unsigned     sh;
    e = (LOG2_1E4_Q32 * idx) / EMBED_HALF;
    n = e >> 32;
    f = e & 64'hFFFF_FFFF;
    x = (f * LN2_Q30) >> 32;
    term = longint'(1) <<< 30;
    sum  = term;
    for (int k = 1; k <= 15; k++) begin
      term = $signed(udiv_small($unsigned((term * longint'(x)) >>> 30), 64'(k)));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    p  = (sum < 0) ? longint'(0) : sum;
    sh = 6 + int'(n);
    w  = (longint'(p) + (longint'(1) << (sh - 1))) >> sh;
    return (w > FREQ_MAX) ? FREQ_MAX[FREQ_W-1:0] : w[FREQ_W-1:0];
  endfunction

  // The table is indexed by the raw field; the wrap modulo EMBED_HALF is folded in.
  function automatic freq_rom_t build_freq_rom();
    freq_rom_t rom;
    for (int i = 0; i < IDX_COUNT; i++) begin
      rom[i] = freq_q24(i % EMBED_HALF);
    end
    return rom;
  endfunction

  localparam freq_rom_t FREQ_ROM = build_freq_rom();

endpackage

`default_nettype wire

// ===== rtl/core/ste_channels.sv =====
`default_nettype none

interface ste_in_if;
  logic                        valid;
  logic                        ready;
  logic [ste_pkg::TS_W-1:0]    timestep;
  logic [ste_pkg::IDX_W-1:0]   freq_index;

  modport source (output valid, timestep, freq_index, input ready);
  modport sink   (input valid, timestep, freq_index, output ready);
endinterface

interface ste_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ste_pkg::OUT_W-1:0] sine_value;
  logic signed [ste_pkg::OUT_W-1:0] cosine_value;
  logic [ste_pkg::IDX_W-1:0]        index_echo;

  modport source (output valid, sine_value, cosine_value, index_echo, input ready);
  modport sink   (input valid, sine_value, cosine_value, index_echo, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sinusoidal_timestep_embedding_top.sv =====
// Sinusoidal timestep embedding, one frequency per word.
// The in_chan channel carries a timestep (unsigned Q11.13) and a frequency
// index. For each accepted word the block returns one word on out_chan with
// sin and cos of timestep * 10000^(-i/EMBED_HALF) in signed Q1.15, plus the raw
// index so the receiver can place the pair at elements i and i+EMBED_HALF.
// A word moves on a channel at a rising edge where valid and ready are high.
// The datapath is a 15-stage pipeline: frequency table read, 24x24 multiply,
// quotient estimate and remainder for the reduction modulo two pi, a final
// correction, the quadrant fold, eight CORDIC stages of three rotations each,
// and the rounding and saturation stage that drives out_chan.
// Throughput is one word per cycle when out_chan does not stall, set by the fully unrolled CORDIC chain.
// Every stage has its own valid bit, and a stage loads whenever it or any
// stage after it is empty, so bubbles close up during a stall. in_chan.ready
// falls only when all 15 stages hold a word and out_chan.ready is low.
// Reset (synchronous, active low) clears the valid bits; nothing else is
// cleared and the frequency table is constant, so the block is usable in the
// cycle after reset is released.
`default_nettype none

module sinusoidal_timestep_embedding_top (
  input  wire        clk,
  input  wire        rst_n,
  ste_in_if.sink     in_chan,
  ste_out_if.source  out_chan
);

  localparam int ST_IN     = 0;
  localparam int ST_MUL    = 1;
  localparam int ST_QUO    = 2;
  localparam int ST_REM    = 3;
  localparam int ST_RED    = 4;
  localparam int ST_FOLD   = 5;
  localparam int ST_CORDIC = 6;
  localparam int ST_OUT    = ST_CORDIC + ste_pkg::CORDIC_STAGES;
  localparam int NSTAGE    = ST_OUT + 1;

  localparam int CW = ste_pkg::CORDIC_W;
  localparam int AW = ste_pkg::ANG_W;
  localparam int FW = ste_pkg::R_W + 2;

  localparam logic signed [CW-1:0] FOLD_Z_MAX =
    CW'(ste_pkg::HALF_PI_Q37 >> ste_pkg::FOLD_SHIFT) + CW'(1);

  // Rounds a Q30 value to Q1.15 with optional negation and saturation.
  function automatic logic signed [ste_pkg::OUT_W-1:0] to_q15(
    input logic signed [CW-1:0] v,
    input logic                 neg
  );
    logic signed [CW+1:0] ve;
    logic signed [CW+1:0] t;
    logic signed [CW-14:0] sh;
    ve = {{2{v[CW-1]}}, v};
    if (neg) begin
      ve = -ve;
    end
    t  = ve + (CW+2)'(16384);
    sh = t[CW+1:15];
    if (sh > (CW-13)'(32767)) begin
      return 16'sh7FFF;
    end else if (sh < -(CW-13)'(32768)) begin
      return 16'sh8000;
    end
    return sh[ste_pkg::OUT_W-1:0];
  endfunction

  // Pipeline control: valid bits travel with the data.
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] rdy;

  genvar gk;
  generate
    for (gk = 0; gk < NSTAGE; gk++) begin : g_ctl
      // A stage may load when it, or any later stage, is empty, or the sink takes.
      assign rdy[gk] = out_chan.ready | ~(&v_r[NSTAGE-1:gk]);
      if (gk == 0) begin : g_first
        assign v_nxt[gk] = rdy[gk] ? in_chan.valid : v_r[gk];
      end else begin : g_rest
        assign v_nxt[gk] = rdy[gk] ? v_r[gk-1] : v_r[gk];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_chan.ready = rdy[ST_IN];

  // Index and fold sign ride along with each word.
  logic [ste_pkg::IDX_W-1:0] idx_r [NSTAGE];
  logic [ST_OUT-1:ST_FOLD]   neg_r;
  logic                      neg_nxt;

  generate
    for (gk = 0; gk < NSTAGE; gk++) begin : g_idx
      if (gk == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (rdy[gk]) begin
            idx_r[gk] <= in_chan.freq_index;
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (rdy[gk]) begin
            idx_r[gk] <= idx_r[gk-1];
          end
        end
      end
    end
    for (gk = ST_FOLD; gk < ST_OUT; gk++) begin : g_neg
      if (gk == ST_FOLD) begin : g_first
        always_ff @(posedge clk) begin
          if (rdy[gk]) begin
            neg_r[gk] <= neg_nxt;
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (rdy[gk]) begin
            neg_r[gk] <= neg_r[gk-1];
          end
        end
      end
    end
  endgenerate

  // Frequency table read and timestep capture.
  logic [ste_pkg::TS_W-1:0]   ts_r;
  logic [ste_pkg::FREQ_W-1:0] w_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_IN]) begin
      ts_r <= in_chan.timestep;
      w_r  <= ste_pkg::FREQ_ROM[in_chan.freq_index];
    end
  end

  // Angle in Q37.
  logic [AW-1:0] ang_nxt;
  logic [AW-1:0] ang_r;

  assign ang_nxt = ts_r * w_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_MUL]) begin
      ang_r <= ang_nxt;
    end
  end

  // Quotient estimate from the top bits; it is the true quotient or one below.
  logic [ste_pkg::QPROD_W-1:0] qprod_nxt;
  logic [ste_pkg::Q_W-1:0]     q_r;
  logic [AW-1:0]               ang_q_r;

  assign qprod_nxt = ang_r[AW-1:32] * ste_pkg::MOD_RECIP;

  always_ff @(posedge clk) begin
    if (rdy[ST_QUO]) begin
      q_r     <= qprod_nxt[ste_pkg::QPROD_W-1:ste_pkg::MOD_SHIFT];
      ang_q_r <= ang_r;
    end
  end

  // Remainder against the estimate, below twice two pi.
  logic [AW:0]                qc_nxt;
  logic [AW:0]                rem_nxt;
  logic [ste_pkg::REM_W-1:0]  r0_r;

  assign qc_nxt  = q_r * ste_pkg::TWO_PI_Q37;
  assign rem_nxt = {1'b0, ang_q_r} - qc_nxt;

  always_ff @(posedge clk) begin
    if (rdy[ST_REM]) begin
      r0_r <= rem_nxt[ste_pkg::REM_W-1:0];
    end
  end

  // Final correction: one conditional subtract.
  logic [ste_pkg::REM_W-1:0] red_nxt;
  logic [ste_pkg::R_W-1:0]   red_r;

  assign red_nxt = (r0_r >= {1'b0, ste_pkg::TWO_PI_Q37}) ?
                   (r0_r - {1'b0, ste_pkg::TWO_PI_Q37}) : r0_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_RED]) begin
      red_r <= red_nxt[ste_pkg::R_W-1:0];
    end
  end

  // Quadrant fold into [-pi/2, pi/2]. Both middle quadrants subtract pi
  // and flip the sign of the results; the last quadrant wraps by two pi.
  logic signed [FW-1:0] rs;
  logic signed [FW-1:0] fs_nxt;
  logic signed [FW-1:0] fz_full;
  logic signed [CW-1:0] fz_r;

  assign rs = $signed({2'b00, red_r});

  always_comb begin
    if (red_r <= ste_pkg::HALF_PI_Q37) begin
      fs_nxt  = rs;
      neg_nxt = 1'b0;
    end else if (red_r < ste_pkg::THREE_HALF_PI) begin
      fs_nxt  = rs - $signed({2'b00, ste_pkg::PI_Q37});
      neg_nxt = 1'b1;
    end else begin
      fs_nxt  = rs - $signed({2'b00, ste_pkg::TWO_PI_Q37});
      neg_nxt = 1'b0;
    end
  end

  assign fz_full = fs_nxt >>> ste_pkg::FOLD_SHIFT;

  always_ff @(posedge clk) begin
    if (rdy[ST_FOLD]) begin
      fz_r <= fz_full[CW-1:0];
    end
  end

  // Rotation-mode CORDIC, three rotations per stage.
  logic signed [CW-1:0] cx_r [ste_pkg::CORDIC_STAGES];
  logic signed [CW-1:0] cy_r [ste_pkg::CORDIC_STAGES];
  logic signed [CW-1:0] cz_r [ste_pkg::CORDIC_STAGES];

  genvar gs;
  generate
    for (gs = 0; gs < ste_pkg::CORDIC_STAGES; gs++) begin : g_cordic
      logic signed [CW-1:0] xi;
      logic signed [CW-1:0] yi;
      logic signed [CW-1:0] zi;
      logic signed [CW-1:0] x_nxt;
      logic signed [CW-1:0] y_nxt;
      logic signed [CW-1:0] z_nxt;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;

      if (gs == 0) begin : g_head
        assign xi = ste_pkg::CORDIC_GAIN_Q30;
        assign yi = '0;
        assign zi = fz_r;
      end else begin : g_body
        assign xi = cx_r[gs-1];
        assign yi = cy_r[gs-1];
        assign zi = cz_r[gs-1];
      end

      always_comb begin
        x_nxt = xi;
        y_nxt = yi;
        z_nxt = zi;
        for (int j = 0; j < ste_pkg::CORDIC_PER_STAGE; j++) begin
          dx = y_nxt >>> (gs * ste_pkg::CORDIC_PER_STAGE + j);
          dy = x_nxt >>> (gs * ste_pkg::CORDIC_PER_STAGE + j);
          if (!z_nxt[CW-1]) begin
            x_nxt = x_nxt - dx;
            y_nxt = y_nxt + dy;
            z_nxt = z_nxt - ste_pkg::ATAN_Q30[gs * ste_pkg::CORDIC_PER_STAGE + j];
          end else begin
            x_nxt = x_nxt + dx;
            y_nxt = y_nxt - dy;
            z_nxt = z_nxt + ste_pkg::ATAN_Q30[gs * ste_pkg::CORDIC_PER_STAGE + j];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[ST_CORDIC + gs]) begin
          cx_r[gs] <= x_nxt;
          cy_r[gs] <= y_nxt;
          cz_r[gs] <= z_nxt;
        end
      end
    end
  endgenerate

  // Output register: rounding, sign from the fold, saturation.
  logic signed [ste_pkg::OUT_W-1:0] sine_nxt;
  logic signed [ste_pkg::OUT_W-1:0] cosine_nxt;
  logic signed [ste_pkg::OUT_W-1:0] sine_r;
  logic signed [ste_pkg::OUT_W-1:0] cosine_r;

  assign sine_nxt   = to_q15(cy_r[ste_pkg::CORDIC_STAGES-1], neg_r[ST_OUT-1]);
  assign cosine_nxt = to_q15(cx_r[ste_pkg::CORDIC_STAGES-1], neg_r[ST_OUT-1]);

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      sine_r   <= sine_nxt;
      cosine_r <= cosine_nxt;
    end
  end

  assign out_chan.valid        = v_r[ST_OUT];
  assign out_chan.sine_value   = sine_r;
  assign out_chan.cosine_value = cosine_r;
  assign out_chan.index_echo   = idx_r[ST_OUT];

  // Input is refused only when every stage is occupied.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (&v_r))
    else $error("input stalled while a pipeline stage was empty");

  // The reduced angle lies below two pi.
  a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_RED] |-> (red_r < ste_pkg::TWO_PI_Q37))
    else $error("angle reduction left a remainder of two pi or more");

  // The folded angle lies within about pi/2 either side of zero.
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_FOLD] |-> ((fz_r <= FOLD_Z_MAX) && (fz_r >= -FOLD_Z_MAX)))
    else $error("folded angle outside the CORDIC range");

  // A held fold stage keeps its word.
  a_fold_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[ST_FOLD] && !rdy[ST_FOLD]) |=> (v_r[ST_FOLD] && $stable(fz_r)))
    else $error("fold stage lost or changed a held word");

endmodule

`default_nettype wire
